FILE: sv/hhmm_pkg.sv
package hhmm_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

    localparam int SEG_W    = 7;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int PRESC_W  = 16;
    localparam int BTN_W    = 3;

    localparam logic [PRESC_W-1:0] PRESCALE_RESET = 16'd1000;

    localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;

    // operation codes carried on the input tuser
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_BUTTONS = 1'b1;

    // button bit positions
    localparam int BTN_UP     = 0;
    localparam int BTN_DOWN   = 1;
    localparam int BTN_TOGGLE = 2;

    // next time-of-day values handed to the display side
    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic              hours_mode;
        logic              rewrite;
    } time_view_t;

    typedef struct packed {
        logic [SEG_W-1:0]      segments;
        logic [NUM_DIGITS-1:0] enables;
    } disp_view_t;

    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // tens digit of a value below 60
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        priority if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40)     t = 4'd4;
        else if (v >= 6'd30)     t = 4'd3;
        else if (v >= 6'd20)     t = 4'd2;
        else if (v >= 6'd10)     t = 4'd1;
        else                     t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] t6;
        logic [5:0] u;
        t6 = {2'b00, tens_of(v)};
        u  = v - (t6 << 3) - (t6 << 1);
        return u[3:0];
    endfunction

endpackage

FILE: sv/hhmm_clock_with_set_and_display_mux.sv
// 24-hour clock with set buttons and a four-digit multiplexed 7-segment drive.
// Each input transaction is either a timer tick (tuser = 0) or a button sample
// (tuser = 1), and each produces exactly one result transaction carrying the
// display drive, the time and the set mode. The state update for one
// transaction is a single pass of logic into the state and result registers,
// so a transaction is accepted every cycle and its result appears on the
// output in the next cycle; the output register stalls intake only while it
// holds a result the sink has not taken. prescale_reload sets the number of
// ticks per second (0 means 65536) and may be written only while idle.
module hhmm_clock_with_set_and_display_mux (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,       // prescale_reload
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [2:0] buttons, [7:3] zero
    input  logic [0:0]  s_axis_tuser,    // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // [6:0] segments, [10:7] digit_enable,
                                         // [15:11] hours_now, [21:16] minutes_now,
                                         // [27:22] seconds_now, [28] setting_hours,
                                         // [31:29] zero
);
    import hhmm_pkg::*;

    logic [PRESC_W-1:0] reload_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic               accept;

    time_view_t tview;
    disp_view_t dview;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reload_reg <= PRESCALE_RESET;
        else if (cfg_we)
            reload_reg <= cfg_wdata;
    end

    hhmm_time u_time (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .operation       (s_axis_tuser[0]),
        .buttons         (s_axis_tdata[BTN_W-1:0]),
        .prescale_reload (reload_reg),
        .view_next       (tview)
    );

    hhmm_display u_display (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (s_axis_tuser[0]),
        .view_next (tview),
        .disp_next (dview)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // display bits always mirror the display latches, reset included
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_data_reg <= '0;
        else if (accept)
            out_data_reg <= {3'b000, tview.hours_mode, tview.seconds, tview.minutes,
                             tview.hours, dview.enables, dview.segments};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("intake open while result is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted transaction produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:11] < 5'd24) && (m_axis_tdata[21:16] < 6'd60)
                          && (m_axis_tdata[27:22] < 6'd60))
        else $error("time field out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_axis_tuser[0] == OP_BUTTONS) |=> $stable(m_axis_tdata[10:0]))
        else $error("button sample changed the digit drive");

endmodule

FILE: sv/hhmm_time.sv
module hhmm_time (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          operation,
    input  logic [hhmm_pkg::BTN_W-1:0]    buttons,
    input  logic [hhmm_pkg::PRESC_W-1:0]  prescale_reload,
    output hhmm_pkg::time_view_t          view_next
);
    import hhmm_pkg::*;

    logic [PRESC_W-1:0] prescaler_reg, prescaler_next;
    logic [SEC_W-1:0]   seconds_reg, seconds_next;
    logic [MIN_W-1:0]   minutes_reg, minutes_next;
    logic [HOUR_W-1:0]  hours_reg, hours_next;
    logic               mode_reg, mode_next;
    logic [BTN_W-1:0]   prev_btn_reg, prev_btn_next;
    logic               rewrite;

    logic [PRESC_W-1:0] presc_dec;
    logic [BTN_W-1:0]   rise;
    logic [MIN_W-1:0]   min_up;
    logic [HOUR_W-1:0]  hrs_up;

    assign presc_dec = prescaler_reg - PRESC_W'(1);
    assign rise      = ~prev_btn_reg & buttons;

    always_comb
    begin
        prescaler_next = prescaler_reg;
        seconds_next   = seconds_reg;
        minutes_next   = minutes_reg;
        hours_next     = hours_reg;
        mode_next      = mode_reg;
        prev_btn_next  = prev_btn_reg;
        rewrite        = 1'b0;
        min_up         = minutes_reg;
        hrs_up         = hours_reg;

        if (operation == OP_TICK)
        begin
            prescaler_next = presc_dec;
            if (presc_dec == '0)
            begin
                prescaler_next = prescale_reload;
                if (seconds_reg >= SEC_LAST)
                begin
                    seconds_next = '0;
                    rewrite      = 1'b1;
                    if (minutes_reg >= MIN_LAST)
                    begin
                        minutes_next = '0;
                        hours_next   = (hours_reg >= HOUR_LAST) ? '0 : hours_reg + HOUR_W'(1);
                    end
                    else
                    begin
                        minutes_next = minutes_reg + MIN_W'(1);
                    end
                end
                else
                begin
                    seconds_next = seconds_reg + SEC_W'(1);
                end
            end
        end
        else
        begin
            prev_btn_next = buttons;
            // up first, then down, both with the mode from before the toggle
            if (rise[BTN_UP])
            begin
                if (mode_reg)
                    hrs_up = (hours_reg >= HOUR_LAST) ? '0 : hours_reg + HOUR_W'(1);
                else
                    min_up = (minutes_reg >= MIN_LAST) ? '0 : minutes_reg + MIN_W'(1);
            end
            hours_next   = hrs_up;
            minutes_next = min_up;
            if (rise[BTN_DOWN])
            begin
                if (mode_reg)
                    hours_next = (hrs_up == '0) ? HOUR_LAST : hrs_up - HOUR_W'(1);
                else
                    minutes_next = (min_up == '0) ? MIN_LAST : min_up - MIN_W'(1);
            end
            rewrite   = rise[BTN_UP] | rise[BTN_DOWN];
            mode_next = mode_reg ^ rise[BTN_TOGGLE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescaler_reg <= '0;
            seconds_reg   <= '0;
            minutes_reg   <= '0;
            hours_reg     <= '0;
            mode_reg      <= 1'b0;
            prev_btn_reg  <= '0;
        end
        else if (accept)
        begin
            prescaler_reg <= prescaler_next;
            seconds_reg   <= seconds_next;
            minutes_reg   <= minutes_next;
            hours_reg     <= hours_next;
            mode_reg      <= mode_next;
            prev_btn_reg  <= prev_btn_next;
        end
    end

    assign view_next.hours      = hours_next;
    assign view_next.minutes    = minutes_next;
    assign view_next.seconds    = seconds_next;
    assign view_next.hours_mode = mode_next;
    assign view_next.rewrite    = rewrite;

endmodule

FILE: sv/hhmm_display.sv
module hhmm_display (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  operation,
    input  hhmm_pkg::time_view_t  view_next,
    output hhmm_pkg::disp_view_t  disp_next
);
    import hhmm_pkg::*;

    logic [SEG_W-1:0]       image_reg [NUM_DIGITS];
    logic [SEG_W-1:0]       image_next [NUM_DIGITS];
    logic [DIGIT_IDX_W-1:0] index_reg, index_next;
    logic [SEG_W-1:0]       seg_reg, seg_next;
    logic [NUM_DIGITS-1:0]  en_reg, en_next;

    logic [DIGIT_IDX_W-1:0] idx_step;
    logic [5:0]             hrs6;

    assign idx_step = (index_reg == DIGIT_IDX_W'(NUM_DIGITS - 1)) ? '0
                                                                  : index_reg + DIGIT_IDX_W'(1);
    assign hrs6 = {1'b0, view_next.hours};

    always_comb
    begin
        seg_next   = seg_reg;
        en_next    = en_reg;
        index_next = index_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
            image_next[i] = image_reg[i];

        // refresh uses the image from before any rewrite in the same transaction
        if (operation == OP_TICK)
        begin
            index_next = idx_step;
            seg_next   = image_reg[idx_step];
            en_next    = (en_reg & ~(NUM_DIGITS'(1) << index_reg)) | (NUM_DIGITS'(1) << idx_step);
        end

        // a rewrite resets the scan index but leaves the enable latch alone
        if (view_next.rewrite)
        begin
            image_next[0] = seg_font(tens_of(hrs6));
            image_next[1] = seg_font(units_of(hrs6));
            image_next[2] = seg_font(tens_of(view_next.minutes));
            image_next[3] = seg_font(units_of(view_next.minutes));
            index_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
                image_reg[i] <= '0;
            index_reg <= '0;
            seg_reg   <= '0;
            en_reg    <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
                image_reg[i] <= image_next[i];
            index_reg <= index_next;
            seg_reg   <= seg_next;
            en_reg    <= en_next;
        end
    end

    assign disp_next.segments = seg_next;
    assign disp_next.enables  = en_next;

endmodule
